// ----- hdl/bdq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types, constants and helpers for the bounded deque with
// remove-by-value.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;

	localparam logic [1:0] FUNC_PUSH_FRONT = 2'd0;
	localparam logic [1:0] FUNC_PUSH_BACK  = 2'd1;
	localparam logic [1:0] FUNC_REMOVE     = 2'd2;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_FIRST_RD,
		ST_LAST_RD,
		ST_LAST_CAP,
		ST_DONE
	} state_t;

	// Reduces head plus offset into the circular store. The sum is always
	// below twice the capacity, so one compare and subtract is enough.
	function automatic logic [IDX_W-1:0] wrap_index(input logic [CNT_W:0] sum);
		logic [CNT_W:0] t;
		t = (sum >= (CNT_W + 1)'(CAPACITY)) ? (sum - (CNT_W + 1)'(CAPACITY)) : sum;
		return t[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- hdl/bdq_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_req_if
// Request channel of the deque: operation code and value.
// ----------------------------------------------------------------------------
interface bdq_req_if;
	import bdq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [1:0]               func;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink   (input valid, input func, input value, output ready);

endinterface
`default_nettype wire

// ----- hdl/bdq_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_rsp_if
// Result channel of the deque: status, front and back values, entry count.
// ----------------------------------------------------------------------------
interface bdq_rsp_if;
	import bdq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] first_value;
	logic signed [DATA_W-1:0] last_value;
	logic [CNT_W-1:0]         count;

	modport source (output valid, output status, output first_value,
		output last_value, output count, input ready);
	modport sink   (input valid, input status, input first_value,
		input last_value, input count, output ready);

endinterface
`default_nettype wire

// ----- hdl/bounded_deque_remove_by_value.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque_remove_by_value
// Ordered list of signed 32-bit values in a circular store, with insert at
// either end and removal of the first entry equal to a given value.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload                                  Per request
//  -------  ---------  ---------------------------------------  -----------
//  req      in         func, value                              one in
//  rsp      out        status, first_value, last_value, count   one out
//
// An insert, an ignored code or a removal from an empty list goes from the
// execute state straight to reading the front and back entries. A removal
// reads and compares entries from the front; a match behind the front shifts
// each later entry forward with a read and a write, a front match only moves
// the head. A list left empty skips both end reads. The store is not cleared
// at reset; only the head index, the count and the control state are. The
// request side stays ready whenever the sequencer is idle, even while a result
// waits; a stalled result holds it in its last state.
//
module bounded_deque_remove_by_value (
	input  wire logic clk,
	input  wire logic arst_n,
	bdq_req_if.sink   req,
	bdq_rsp_if.source rsp
);
	import bdq_pkg::*;

	// Sequencer and list state.
	state_t             state_q, state_n;
	logic [IDX_W-1:0]   head_q, head_n;
	logic [CNT_W-1:0]   count_q, count_n;
	logic [CNT_W-1:0]   pos_q, pos_n;
	logic               out_valid_q, out_valid_n;

	// Request and working payload.
	logic [1:0]               func_q;
	logic signed [DATA_W-1:0] value_q;
	status_t                  status_q, status_n;
	logic signed [DATA_W-1:0] first_q, first_n;
	logic signed [DATA_W-1:0] last_q, last_n;

	// Result register payload.
	status_t                  out_status_q;
	logic signed [DATA_W-1:0] out_first_q;
	logic signed [DATA_W-1:0] out_last_q;
	logic [CNT_W-1:0]         out_count_q;

	// Circular store and its one shared address unit.
	logic signed [DATA_W-1:0] mem [CAPACITY];
	logic signed [DATA_W-1:0] rd_q;
	logic signed [DATA_W-1:0] wr_data;
	logic                     mem_we;
	logic [CNT_W-1:0]         addr_off;
	logic [IDX_W-1:0]         mem_addr;
	logic [CNT_W-1:0]         pos_inc;
	logic                     load_out;
	logic                     accept;

	assign accept  = req.valid && req.ready;
	assign pos_inc = pos_q + CNT_W'(1);

	// Every store address, and the head update, goes through this one adder.
	assign mem_addr = wrap_index({1'b0, CNT_W'(head_q)} + {1'b0, addr_off});

	always_comb begin
		state_n     = state_q;
		head_n      = head_q;
		count_n     = count_q;
		pos_n       = pos_q;
		status_n    = status_q;
		first_n     = first_q;
		last_n      = last_q;
		mem_we      = 1'b0;
		wr_data     = value_q;
		addr_off    = pos_q;
		load_out    = 1'b0;
		req.ready   = (state_q == ST_IDLE);

		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_n = ST_EXEC;
				end
			end
			ST_EXEC: begin
				status_n = STAT_OK;
				state_n  = ST_FIRST_RD;
				unique case (func_q)
					FUNC_PUSH_FRONT: begin
						addr_off = CNT_W'(CAPACITY - 1);
						if (count_q == CNT_W'(CAPACITY)) begin
							status_n = STAT_FULL;
						end else begin
							mem_we  = 1'b1;
							head_n  = mem_addr;
							count_n = count_q + CNT_W'(1);
						end
					end
					FUNC_PUSH_BACK: begin
						addr_off = count_q;
						if (count_q == CNT_W'(CAPACITY)) begin
							status_n = STAT_FULL;
						end else begin
							mem_we  = 1'b1;
							count_n = count_q + CNT_W'(1);
						end
					end
					FUNC_REMOVE: begin
						if (count_q == '0) begin
							status_n = STAT_EMPTY;
						end else begin
							pos_n   = '0;
							state_n = ST_SRCH_RD;
						end
					end
					default: begin
						// Unused code: report the current snapshot.
					end
				endcase
			end
			ST_SRCH_RD: begin
				addr_off = pos_q;
				state_n  = ST_SRCH_CMP;
			end
			ST_SRCH_CMP: begin
				addr_off = CNT_W'(1);
				if (rd_q == value_q) begin
					if (pos_q == '0) begin
						// Front entry matched: just advance the head.
						head_n  = mem_addr;
						count_n = count_q - CNT_W'(1);
						state_n = ST_FIRST_RD;
					end else begin
						state_n = ST_SHIFT_RD;
					end
				end else if (pos_inc == count_q) begin
					status_n = STAT_NOT_FOUND;
					state_n  = ST_FIRST_RD;
				end else begin
					pos_n   = pos_inc;
					state_n = ST_SRCH_RD;
				end
			end
			ST_SHIFT_RD: begin
				addr_off = pos_inc;
				if (pos_inc < count_q) begin
					state_n = ST_SHIFT_WR;
				end else begin
					count_n = count_q - CNT_W'(1);
					state_n = ST_FIRST_RD;
				end
			end
			ST_SHIFT_WR: begin
				addr_off = pos_q;
				mem_we   = 1'b1;
				wr_data  = rd_q;
				pos_n    = pos_inc;
				state_n  = ST_SHIFT_RD;
			end
			ST_FIRST_RD: begin
				addr_off = '0;
				if (count_q == '0) begin
					first_n = '0;
					last_n  = '0;
					state_n = ST_DONE;
				end else begin
					state_n = ST_LAST_RD;
				end
			end
			ST_LAST_RD: begin
				first_n  = rd_q;
				addr_off = count_q - CNT_W'(1);
				state_n  = ST_LAST_CAP;
			end
			ST_LAST_CAP: begin
				last_n  = rd_q;
				state_n = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase

		if (load_out) begin
			out_valid_n = 1'b1;
		end else if (rsp.ready) begin
			out_valid_n = 1'b0;
		end else begin
			out_valid_n = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			head_q      <= head_n;
			count_q     <= count_n;
			pos_q       <= pos_n;
			out_valid_q <= out_valid_n;
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= req.func;
			value_q <= req.value;
		end
		status_q <= status_n;
		first_q  <= first_n;
		last_q   <= last_n;
		if (load_out) begin
			out_status_q <= status_q;
			out_first_q  <= first_q;
			out_last_q   <= last_q;
			out_count_q  <= count_q;
		end
	end

	// Single-port store with a registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= wr_data;
		end
		rd_q <= mem[mem_addr];
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.first_value = out_first_q;
	assign rsp.last_value  = out_last_q;
	assign rsp.count       = out_count_q;

endmodule
`default_nettype wire

// ----- tb/sv/tb_bounded_deque_remove_by_value.sv -----
// ----------------------------------------------------------------------------
// tb_bounded_deque_remove_by_value
// Self-checking bench for the bounded deque. Requests go in over the req
// channel in random bursts, and every result taken from the rsp channel is
// compared field by field against a cycle-free model of the list kept here.
// ----------------------------------------------------------------------------
module tb_bounded_deque_remove_by_value;
	timeunit 1ns;
	timeprecision 1ps;

	import bdq_pkg::*;

	// The block ignores the fourth operation code; it is not in the package.
	localparam logic [1:0] FUNC_IGNORED = 2'd3;

	localparam logic [DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
	localparam logic [DATA_W-1:0] VAL_ONES = 32'hffff_ffff;

	// The stall watchdog allows the long receiver hold-off plus a removal at
	// full capacity, with a wide margin.
	localparam int LONG_HOLD = 300;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 80;
	localparam int MAX_REPORTS = 100;

	typedef enum int {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PERIODIC
	} rx_mode_t;

	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] first_value;
		logic [DATA_W-1:0] last_value;
		logic [CNT_W-1:0]  count;
	} deque_result_t;

	logic clk;
	logic arst_n;

	bdq_req_if req ();
	bdq_rsp_if rsp ();

	bounded_deque_remove_by_value dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Mirror of the list: circular store, head position and occupancy.
	logic [DATA_W-1:0] deque_store [CAPACITY];
	int                deque_head;
	int                deque_count;

	// Results predicted for accepted requests, oldest first.
	deque_result_t pending_results [$];

	int error_count;
	int inserts_sent, removes_sent, ignored_sent;
	int full_seen, not_found_seen, empty_seen;

	// Sender pacing, set per test. A zero gap limit means back-to-back.
	int tx_gap_max;
	int tx_burst_left;

	// Receiver pacing. The hold-off is requested by bumping hold_requests;
	// only the receiver process touches hold_served and its own counter.
	rx_mode_t rx_mode;
	int       rx_stall_pct;
	int       hold_requests;

	// Pool of values reused within a phase so duplicates show up often.
	logic [DATA_W-1:0] value_pool [6];

	// ------------------------------------------------------------------------
	// Clock and watchdog.
	// ------------------------------------------------------------------------
	initial begin : clock_gen
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Counts cycles in which neither channel moves a request or a result.
	// The slowest legal case is the long hold-off on top of a full removal.
	initial begin : stall_watchdog
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
					idle_cycles, pending_results.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Predictor. Applies one accepted request to the mirror and queues the
	// result the block must return for it.
	// ------------------------------------------------------------------------
	function automatic int deque_slot(input int offset);
		return (deque_head + offset) % CAPACITY;
	endfunction

	task automatic deque_apply(input logic [1:0] func, input logic [DATA_W-1:0] value);
		deque_result_t res;
		int pos;
		res.status = STAT_OK;
		case (func)
			FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
				inserts_sent++;
				if (deque_count >= CAPACITY) begin
					res.status = STAT_FULL;
				end else if (func == FUNC_PUSH_FRONT) begin
					deque_head = (deque_head + CAPACITY - 1) % CAPACITY;
					deque_store[deque_head] = value;
					deque_count++;
				end else begin
					deque_store[deque_slot(deque_count)] = value;
					deque_count++;
				end
			end
			FUNC_REMOVE: begin
				removes_sent++;
				if (deque_count == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					// Search from the front; only the nearest match goes.
					pos = 0;
					while (pos < deque_count && deque_store[deque_slot(pos)] != value)
						pos++;
					if (pos == deque_count) begin
						res.status = STAT_NOT_FOUND;
					end else begin
						if (pos == 0) begin
							deque_head = deque_slot(1);
						end else begin
							// Close the gap by pulling the tail forward.
							for (int k = pos; k + 1 < deque_count; k++)
								deque_store[deque_slot(k)] = deque_store[deque_slot(k + 1)];
						end
						deque_count--;
					end
				end
			end
			default: begin
				ignored_sent++;
			end
		endcase
		case (res.status)
			STAT_FULL:      full_seen++;
			STAT_NOT_FOUND: not_found_seen++;
			STAT_EMPTY:     empty_seen++;
			default:        ;
		endcase
		// An empty list reports zero at both ends.
		if (deque_count > 0) begin
			res.first_value = deque_store[deque_head];
			res.last_value  = deque_store[deque_slot(deque_count - 1)];
		end else begin
			res.first_value = '0;
			res.last_value  = '0;
		end
		res.count = CNT_W'(deque_count);
		pending_results.push_back(res);
	endtask

	// ------------------------------------------------------------------------
	// Result checker. Takes each accepted result at the rising edge and
	// compares it against the oldest prediction.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		deque_result_t exp_res;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$error("result with no request outstanding: status %0d count %0d",
						rsp.status, rsp.count);
			end else begin
				exp_res = pending_results.pop_front();
				if (rsp.status !== exp_res.status) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$error("status: expected %s, actual %0d",
							exp_res.status.name(), rsp.status);
				end
				if (rsp.first_value !== exp_res.first_value) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$error("first_value: expected %0d, actual %0d",
							$signed(exp_res.first_value), rsp.first_value);
				end
				if (rsp.last_value !== exp_res.last_value) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$error("last_value: expected %0d, actual %0d",
							$signed(exp_res.last_value), rsp.last_value);
				end
				if (rsp.count !== exp_res.count) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$error("count: expected %0d, actual %0d", exp_res.count, rsp.count);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result receiver. Drives ready at the falling edge following the mode
	// the current test picked, and serves long hold-offs on request.
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int hold_served;
		int hold_left;
		int period_pos;
		hold_served = 0;
		hold_left = 0;
		period_pos = 0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			period_pos = (period_pos + 1) % 11;
			if (hold_left > 0) begin
				rsp.ready = 1'b0;
				hold_left--;
			end else if (hold_requests != hold_served) begin
				hold_served++;
				hold_left = LONG_HOLD - 1;
				rsp.ready = 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS: rsp.ready = 1'b1;
					RX_RANDOM: rsp.ready = ($urandom_range(0, 99) >= rx_stall_pct);
					// Ready on a repeating on/off pattern, so stalls slide across
					// the block's own schedule.
					default:   rsp.ready = (period_pos < 6);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Request sender. Inputs change only at the falling edge; the request
	// stays on the bus until the rising edge where ready is seen high.
	// ------------------------------------------------------------------------
	task automatic send_request(input logic [1:0] func, input logic [DATA_W-1:0] value);
		int gap;
		if (tx_gap_max > 0) begin
			if (tx_burst_left == 0) begin
				gap = $urandom_range(1, tx_gap_max);
				tx_burst_left = $urandom_range(1, 12);
				@(negedge clk);
				// Idle bus carries junk; the block must not act on it.
				req.valid = 1'b0;
				req.func  = 2'($urandom);
				req.value = $urandom;
				repeat (gap) @(posedge clk);
			end
			tx_burst_left--;
		end
		@(negedge clk);
		req.valid = 1'b1;
		req.func  = func;
		req.value = value;
		do @(posedge clk); while (!req.ready);
		deque_apply(func, value);
	endtask

	// Drops valid once a test's last request is taken.
	task automatic release_bus();
		@(negedge clk);
		req.valid = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------
	task automatic refill_value_pool();
		for (int i = 0; i < 6; i++)
			value_pool[i] = ($urandom_range(0, 1) == 0) ? DATA_W'($urandom_range(0, 20)) - 10
				: $urandom;
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			return value_pool[$urandom_range(0, 5)];
		end else if (r < 75) begin
			return $urandom;
		end else if (r < 87) begin
			case ($urandom_range(0, 3))
				0:       return VAL_MAX;
				1:       return VAL_MIN;
				2:       return VAL_ONES;
				default: return '0;
			endcase
		end
		return DATA_W'($urandom_range(0, 16)) - 8;
	endfunction

	// Random traffic. Most requests are inserts and removals of values that
	// are really held, so the search and shift paths get exercised at every
	// depth; the rest are misses, removals from empty and ignored codes.
	// With swing set, the insert share flips whenever the list hits either
	// end, so it goes full and empty over and over.
	task automatic run_random(input int n_items, input int insert_pct, input bit swing);
		int r;
		int pct;
		bit filling;
		logic [1:0]        func;
		logic [DATA_W-1:0] value;
		filling = 1'b1;
		refill_value_pool();
		for (int i = 0; i < n_items; i++) begin
			if (i % 150 == 149)
				refill_value_pool();
			if (swing) begin
				if (deque_count >= CAPACITY)
					filling = 1'b0;
				else if (deque_count == 0)
					filling = 1'b1;
				pct = filling ? 85 : 15;
			end else begin
				pct = insert_pct;
			end
			r = $urandom_range(0, 99);
			if (r < 3) begin
				func  = FUNC_IGNORED;
				value = $urandom;
			end else if ($urandom_range(0, 99) < pct) begin
				func  = $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
				value = pick_value();
			end else begin
				func = FUNC_REMOVE;
				if (deque_count > 0 && $urandom_range(0, 99) < 80)
					value = deque_store[deque_slot($urandom_range(0, deque_count - 1))];
				else
					value = pick_value();
			end
			send_request(func, value);
		end
		release_bus();
	endtask

	// ------------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------------

	// Edge cases in a fixed order: removal and an ignored code on an empty
	// list, the value extremes at both ends, a miss, removal from the middle,
	// front and back, duplicates, and inserts into a full list.
	task automatic test_directed_edges();
		tx_gap_max = 3;
		tx_burst_left = 0;
		rx_mode = RX_RANDOM;
		rx_stall_pct = 30;
		send_request(FUNC_REMOVE, 32'd1);
		send_request(FUNC_IGNORED, '0);
		send_request(FUNC_PUSH_FRONT, VAL_MAX);
		send_request(FUNC_PUSH_BACK, VAL_MIN);
		send_request(FUNC_PUSH_FRONT, '0);
		send_request(FUNC_PUSH_BACK, VAL_ONES);
		send_request(FUNC_REMOVE, 32'd12345);
		send_request(FUNC_REMOVE, VAL_MIN);
		send_request(FUNC_REMOVE, '0);
		send_request(FUNC_REMOVE, VAL_ONES);
		send_request(FUNC_IGNORED, VAL_ONES);
		// Two copies of the same value; only the one nearer the front goes.
		send_request(FUNC_PUSH_BACK, 32'd5);
		send_request(FUNC_PUSH_BACK, 32'd7);
		send_request(FUNC_PUSH_FRONT, 32'd5);
		send_request(FUNC_REMOVE, 32'd5);
		while (deque_count < CAPACITY)
			send_request($urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT, $urandom);
		send_request(FUNC_PUSH_BACK, VAL_MAX);
		send_request(FUNC_PUSH_FRONT, VAL_MIN);
		send_request(FUNC_REMOVE, 32'd7);
		release_bus();
	endtask

	// Back-to-back requests with the receiver always ready.
	task automatic test_random_steady();
		tx_gap_max = 0;
		rx_mode = RX_ALWAYS;
		run_random(300, 55, 1'b0);
	endtask

	// Bursts and gaps on the sender against random stalls on the receiver.
	task automatic test_random_bursty();
		tx_gap_max = 12;
		tx_burst_left = 0;
		rx_mode = RX_RANDOM;
		rx_stall_pct = 40;
		run_random(600, 55, 1'b0);
	endtask

	// The receiver stops for a long stretch while requests keep coming, so
	// the result register stays occupied and the request side must stall.
	task automatic test_backpressure();
		tx_gap_max = 0;
		rx_mode = RX_ALWAYS;
		hold_requests++;
		run_random(40, 60, 1'b0);
		rx_mode = RX_RANDOM;
		rx_stall_pct = 20;
		hold_requests++;
		run_random(40, 40, 1'b0);
	endtask

	// Repeated fill to capacity and drain to empty against a periodic stall.
	task automatic test_fill_drain();
		tx_gap_max = 4;
		tx_burst_left = 0;
		rx_mode = RX_PERIODIC;
		run_random(600, 50, 1'b1);
	endtask

	// A closing stretch that leans toward removals with heavy stalls.
	task automatic test_random_drain_heavy();
		tx_gap_max = 6;
		tx_burst_left = 0;
		rx_mode = RX_RANDOM;
		rx_stall_pct = 70;
		run_random(200, 35, 1'b0);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------------
	initial begin : test_sequence
		req.valid = 1'b0;
		req.func  = '0;
		req.value = '0;
		arst_n = 1'b0;
		deque_head = 0;
		deque_count = 0;
		error_count = 0;
		inserts_sent = 0;
		removes_sent = 0;
		ignored_sent = 0;
		full_seen = 0;
		not_found_seen = 0;
		empty_seen = 0;
		tx_gap_max = 0;
		tx_burst_left = 0;
		rx_mode = RX_ALWAYS;
		rx_stall_pct = 0;
		hold_requests = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_edges();
		test_random_steady();
		test_random_bursty();
		test_backpressure();
		test_fill_drain();
		test_random_drain_heavy();

		// Let the receiver run free so every outstanding result comes back.
		rx_mode = RX_ALWAYS;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d inserts, %0d removals and %0d ignored codes.",
			inserts_sent, removes_sent, ignored_sent);
		$display("Results seen with full %0d, not found %0d, empty %0d; %0d errors.",
			full_seen, not_found_seen, empty_seen, error_count);
		if (error_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/bdq_pkg.sv
hdl/bdq_req_if.sv
hdl/bdq_rsp_if.sv
hdl/bounded_deque_remove_by_value.sv
tb/sv/tb_bounded_deque_remove_by_value.sv
